// ===== hdl/hawm_pkg.sv =====
// Shared types, constants and helpers for the hysteresis alarm window manager.
package hawm_pkg;

    localparam int CODE_W = 16;

    localparam logic [CODE_W-1:0] CODE_MIN = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_MAX = 16'hBFFF;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register map, word index in paddr[3:2]
    typedef enum logic [1:0] {
        REG_LOW_SET    = 2'd0,
        REG_LOW_CLEAR  = 2'd1,
        REG_HIGH_SET   = 2'd2,
        REG_HIGH_CLEAR = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CODE_W-1:0] low_set;
        logic [CODE_W-1:0] low_clear;
        logic [CODE_W-1:0] high_set;
        logic [CODE_W-1:0] high_clear;
    } t_thresholds;

    typedef struct packed {
        logic [CODE_W-1:0] next_low_limit;
        logic [CODE_W-1:0] next_high_limit;
        logic              run_continuous;
        logic              alarm_flag;
        logic              alarm_enabled;
    } t_result;

    // Clamp a written value to the legal code range
    function automatic logic [CODE_W-1:0] sat_code(input logic [DATA_W-1:0] v);
        logic [CODE_W-1:0] lo;
        lo = v[CODE_W-1:0];
        return (lo > CODE_MAX) ? CODE_MAX : lo;
    endfunction

endpackage

// ===== hdl/hawm_cfg_regs.sv =====
// APB threshold registers with saturation on write.
module hawm_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hawm_pkg::ADDR_W-1:0]   paddr,
    input  logic [hawm_pkg::DATA_W-1:0]   pwdata,
    output logic [hawm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output hawm_pkg::t_thresholds         o_thr
);

    hawm_pkg::t_thresholds     r_thr;
    logic                      wr_en;
    hawm_pkg::t_reg_idx        idx;
    logic [hawm_pkg::CODE_W-1:0] wval;
    logic [hawm_pkg::CODE_W-1:0] rval;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = hawm_pkg::t_reg_idx'(paddr[3:2]);
    assign wval   = hawm_pkg::sat_code(pwdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.low_set    <= hawm_pkg::CODE_MIN;
            r_thr.low_clear  <= hawm_pkg::CODE_MIN;
            r_thr.high_set   <= hawm_pkg::CODE_MAX;
            r_thr.high_clear <= hawm_pkg::CODE_MAX;
        end else if (wr_en) begin
            unique case (idx)
                hawm_pkg::REG_LOW_SET:    r_thr.low_set    <= wval;
                hawm_pkg::REG_LOW_CLEAR:  r_thr.low_clear  <= wval;
                hawm_pkg::REG_HIGH_SET:   r_thr.high_set   <= wval;
                hawm_pkg::REG_HIGH_CLEAR: r_thr.high_clear <= wval;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            hawm_pkg::REG_LOW_SET:    rval = r_thr.low_set;
            hawm_pkg::REG_LOW_CLEAR:  rval = r_thr.low_clear;
            hawm_pkg::REG_HIGH_SET:   rval = r_thr.high_set;
            hawm_pkg::REG_HIGH_CLEAR: rval = r_thr.high_clear;
            default:                  rval = '0;
        endcase
    end

    assign prdata = {{(hawm_pkg::DATA_W-hawm_pkg::CODE_W){1'b0}}, rval};
    assign o_thr  = r_thr;

endmodule

// ===== hdl/hawm_window.sv =====
// Window compare: next interrupt limits, mode and next alarm flag for one sample.
module hawm_window (
    input  hawm_pkg::t_thresholds          i_thr,
    input  logic                           i_kind,
    input  logic [hawm_pkg::CODE_W-1:0]    i_code,
    input  logic                           i_alarm,
    output hawm_pkg::t_result              o_res,
    output logic                           o_alarm_next
);

    logic                        use_lo, use_hi, good, enabled;
    logic [hawm_pkg::CODE_W-1:0] ls, lc, hs, hc;
    logic [hawm_pkg::CODE_W-1:0] lo_lim, hi_lim;
    logic                        flag;

    always_comb begin
        use_lo  = (i_thr.low_set != '0) && (i_thr.low_clear != '0);
        use_hi  = (i_thr.high_set != '0) && (i_thr.high_clear != '0);
        good    = !(use_lo && (i_thr.low_clear < i_thr.low_set)) &&
                  !(use_hi && (i_thr.high_clear > i_thr.high_set));
        enabled = good && (use_lo || use_hi);

        // disabled sides collapse onto the ends of the code range
        ls = use_lo ? i_thr.low_set    : hawm_pkg::CODE_MIN;
        lc = use_lo ? i_thr.low_clear  : hawm_pkg::CODE_MIN;
        hs = use_hi ? i_thr.high_set   : hawm_pkg::CODE_MAX;
        hc = use_hi ? i_thr.high_clear : hawm_pkg::CODE_MAX;

        lo_lim = hawm_pkg::CODE_MIN;
        hi_lim = hawm_pkg::CODE_MAX;
        flag   = i_alarm;

        if (enabled) begin
            if (i_code >= lc && i_code <= hc) begin
                lo_lim = ls;
                hi_lim = hs;
            end else if (i_code <= ls) begin
                hi_lim = lc;
            end else if (i_code >= hs) begin
                lo_lim = hc;
            end else if (i_code < lc) begin
                // inside low hysteresis band
                if (i_alarm) begin
                    hi_lim = lc;
                end else begin
                    lo_lim = ls;
                    hi_lim = hs;
                end
            end else begin
                // inside high hysteresis band
                if (i_alarm) begin
                    lo_lim = hc;
                end else begin
                    lo_lim = ls;
                    hi_lim = hs;
                end
            end
            if (i_kind) begin
                flag = i_alarm ? (i_code < lc || i_code > hc)
                               : (i_code <= ls || i_code >= hs);
            end
        end

        o_res.next_low_limit  = lo_lim;
        o_res.next_high_limit = hi_lim;
        o_res.run_continuous  = !(lo_lim == hawm_pkg::CODE_MIN &&
                                  hi_lim == hawm_pkg::CODE_MAX);
        o_res.alarm_flag      = flag;
        o_res.alarm_enabled   = enabled;
        o_alarm_next          = flag;
    end

endmodule

// ===== hdl/hysteresis_alarm_window_manager.sv =====
// Top level: input register, window compare, result register and alarm flag.
// One sample is taken per clock while o_ready is high. A sample goes into an input register and
// its result is loaded into the result register once that register is empty or being read, which
// raises o_valid; the output transfer takes the result from there. The alarm flag is
// updated as the sample moves into the result register, so back-to-back interrupt samples each
// see the flag left by the one before. o_ready follows i_ready combinationally through the
// two-entry pipeline: the input side keeps taking samples while a result waits, until both
// stages hold an item. Thresholds are written over the APB port (byte addresses 0x0, 0x4, 0x8,
// 0xC); values above 0xBFFF are clamped on write.
module hysteresis_alarm_window_manager (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [hawm_pkg::CODE_W-1:0]   i_sample_code,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [hawm_pkg::CODE_W-1:0]   o_next_low_limit,
    output logic [hawm_pkg::CODE_W-1:0]   o_next_high_limit,
    output logic                          o_run_continuous,
    output logic                          o_alarm_flag,
    output logic                          o_alarm_enabled,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hawm_pkg::ADDR_W-1:0]   paddr,
    input  logic [hawm_pkg::DATA_W-1:0]   pwdata,
    output logic [hawm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    hawm_pkg::t_thresholds        thr;
    hawm_pkg::t_result            res;
    logic                         alarm_next;

    logic                         r_in_valid;
    logic                         r_in_kind;
    logic [hawm_pkg::CODE_W-1:0]  r_in_code;
    logic                         r_out_valid;
    hawm_pkg::t_result            r_out;
    logic                         r_alarm;

    logic                         out_load;
    logic                         in_load;

    hawm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_thr   (thr)
    );

    hawm_window u_win (
        .i_thr        (thr),
        .i_kind       (r_in_kind),
        .i_code       (r_in_code),
        .i_alarm      (r_alarm),
        .o_res        (res),
        .o_alarm_next (alarm_next)
    );

    assign out_load = !r_out_valid || i_ready;
    assign o_ready  = !r_in_valid || out_load;
    assign in_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_alarm     <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_alarm <= alarm_next;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_kind <= i_kind;
            r_in_code <= i_sample_code;
        end
        if (out_load && r_in_valid) begin
            r_out <= res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_next_low_limit  = r_out.next_low_limit;
    assign o_next_high_limit = r_out.next_high_limit;
    assign o_run_continuous  = r_out.run_continuous;
    assign o_alarm_flag      = r_out.alarm_flag;
    assign o_alarm_enabled   = r_out.alarm_enabled;

`ifndef ASSERT_OFF
    a_disabled_full_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_alarm_enabled) |->
            (o_next_low_limit == hawm_pkg::CODE_MIN &&
             o_next_high_limit == hawm_pkg::CODE_MAX && !o_run_continuous))
        else $error("disabled alarm must report full-range limits in shutdown");

    a_shutdown_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_run_continuous) |->
            (o_next_low_limit == hawm_pkg::CODE_MIN &&
             o_next_high_limit == hawm_pkg::CODE_MAX))
        else $error("shutdown reported with limits not spanning full range");

    a_flag_only_on_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(out_load && r_in_valid && r_in_kind) |=> $stable(r_alarm))
        else $error("alarm flag changed without an interrupt sample");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_load) |=> r_in_valid)
        else $error("stalled sample dropped from input register");
`endif

endmodule

// ===== bench/hysteresis_alarm_window_manager_tb.sv =====
// Testbench for the hysteresis alarm window manager: APB threshold setup, sample stream, checking.
module hysteresis_alarm_window_manager_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic                          i_kind;
    logic [hawm_pkg::CODE_W-1:0]   i_sample_code;
    logic                          o_valid;
    logic                          i_ready;
    logic [hawm_pkg::CODE_W-1:0]   o_next_low_limit;
    logic [hawm_pkg::CODE_W-1:0]   o_next_high_limit;
    logic                          o_run_continuous;
    logic                          o_alarm_flag;
    logic                          o_alarm_enabled;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [hawm_pkg::ADDR_W-1:0]   paddr;
    logic [hawm_pkg::DATA_W-1:0]   pwdata;
    logic [hawm_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    hawm_pkg::t_thresholds thr;    // thresholds as held by the block, already clamped
    logic                  in_alarm;
    hawm_pkg::t_result     pending_limits[$];
    int                    n_fail = 0;
    int                    hold_left = 0;
    bit                    sink_jitter = 1'b1;
    bit                    src_jitter = 1'b1;

    hysteresis_alarm_window_manager u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Window compare with hysteresis; interrupt samples also move the alarm flag.
    function automatic hawm_pkg::t_result window_step(input logic irq,
                                                      input logic [hawm_pkg::CODE_W-1:0] v);
        logic [hawm_pkg::CODE_W-1:0] ls, lc, hs, hc;
        logic                        lo_on, hi_on, ordered, armed;
        hawm_pkg::t_result           r;
        ls = thr.low_set;
        lc = thr.low_clear;
        hs = thr.high_set;
        hc = thr.high_clear;
        lo_on = (ls != '0) && (lc != '0);
        hi_on = (hs != '0) && (hc != '0);
        ordered = !(lo_on && lc < ls) && !(hi_on && hc > hs);
        if (!lo_on) begin
            ls = hawm_pkg::CODE_MIN;
            lc = hawm_pkg::CODE_MIN;
        end
        if (!hi_on) begin
            hs = hawm_pkg::CODE_MAX;
            hc = hawm_pkg::CODE_MAX;
        end
        armed = ordered && (lo_on || hi_on);
        r.next_low_limit = hawm_pkg::CODE_MIN;
        r.next_high_limit = hawm_pkg::CODE_MAX;
        r.alarm_flag = in_alarm;
        if (armed) begin
            if (v >= lc && v <= hc) begin
                r.next_low_limit = ls;
                r.next_high_limit = hs;
            end else if (v <= ls) begin
                r.next_high_limit = lc;
            end else if (v >= hs) begin
                r.next_low_limit = hc;
            end else if (v < lc) begin
                if (in_alarm) begin
                    r.next_high_limit = lc;
                end else begin
                    r.next_low_limit = ls;
                    r.next_high_limit = hs;
                end
            end else begin
                if (in_alarm) begin
                    r.next_low_limit = hc;
                end else begin
                    r.next_low_limit = ls;
                    r.next_high_limit = hs;
                end
            end
            // flag update sees the flag left by the previous sample
            if (irq) begin
                in_alarm = in_alarm ? (v < lc || v > hc) : (v <= ls || v >= hs);
                r.alarm_flag = in_alarm;
            end
        end
        r.run_continuous = !(r.next_low_limit == hawm_pkg::CODE_MIN &&
                             r.next_high_limit == hawm_pkg::CODE_MAX);
        r.alarm_enabled = armed;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [hawm_pkg::CODE_W-1:0] want,
                               input logic [hawm_pkg::CODE_W-1:0] got);
        if (got !== want) begin
            if (n_fail < 50)
                $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_fail++;
        end
    endtask

    // Result side: random stalls, plus a long hold-off on request
    initial begin : sink
        int stall_left;
        stall_left = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (sink_jitter && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Handshake signals are stable at the falling edge; the transfer happens at the next rise
    initial begin : monitor
        hawm_pkg::t_result want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_limits.size() == 0) begin
                    if (n_fail < 50)
                        $display("%0t ns: result with none expected, expected none, actual %h %h",
                                 $time, o_next_low_limit, o_next_high_limit);
                    n_fail++;
                end else begin
                    want = pending_limits.pop_front();
                    check_field("next_low_limit", want.next_low_limit, o_next_low_limit);
                    check_field("next_high_limit", want.next_high_limit, o_next_high_limit);
                    check_field("run_continuous", 16'(want.run_continuous),
                                16'(o_run_continuous));
                    check_field("alarm_flag", 16'(want.alarm_flag), 16'(o_alarm_flag));
                    check_field("alarm_enabled", 16'(want.alarm_enabled),
                                16'(o_alarm_enabled));
                end
            end
        end
    end

    task automatic send_sample(input logic irq, input logic [hawm_pkg::CODE_W-1:0] code);
        logic took;
        if (src_jitter && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= irq;
        i_sample_code <= code;
        do begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end while (!took);
        pending_limits.push_back(window_step(irq, code));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_limits.size() != 0);
    endtask

    task automatic write_reg(input hawm_pkg::t_reg_idx idx,
                             input logic [hawm_pkg::DATA_W-1:0] data);
        logic [hawm_pkg::CODE_W-1:0] lvl;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        lvl = (data[hawm_pkg::CODE_W-1:0] > hawm_pkg::CODE_MAX) ? hawm_pkg::CODE_MAX
                                                                 : data[hawm_pkg::CODE_W-1:0];
        case (idx)
            hawm_pkg::REG_LOW_SET:    thr.low_set = lvl;
            hawm_pkg::REG_LOW_CLEAR:  thr.low_clear = lvl;
            hawm_pkg::REG_HIGH_SET:   thr.high_set = lvl;
            hawm_pkg::REG_HIGH_CLEAR: thr.high_clear = lvl;
            default: ;
        endcase
    endtask

    // upper data bits are don't-care, so they get random content
    task automatic set_window(input logic [hawm_pkg::CODE_W-1:0] ls,
                              input logic [hawm_pkg::CODE_W-1:0] lc,
                              input logic [hawm_pkg::CODE_W-1:0] hs,
                              input logic [hawm_pkg::CODE_W-1:0] hc);
        write_reg(hawm_pkg::REG_LOW_SET, {16'($urandom), ls});
        write_reg(hawm_pkg::REG_LOW_CLEAR, {16'($urandom), lc});
        write_reg(hawm_pkg::REG_HIGH_SET, {16'($urandom), hs});
        write_reg(hawm_pkg::REG_HIGH_CLEAR, {16'($urandom), hc});
    endtask

    function automatic logic [hawm_pkg::CODE_W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return hawm_pkg::CODE_MAX;
            3: return 16'hC000;
            4: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Half of the codes lie right around a threshold, where the hysteresis decisions flip
    function automatic logic [hawm_pkg::CODE_W-1:0] pick_code();
        int base;
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            case ($urandom_range(0, 3))
                0: base = int'(thr.low_set);
                1: base = int'(thr.low_clear);
                2: base = int'(thr.high_set);
                default: base = int'(thr.high_clear);
            endcase
            base = base + int'($urandom_range(0, 6)) - 3;
            if (base < 0) base = 0;
            if (base > 16'hFFFF) base = 16'hFFFF;
            return base[hawm_pkg::CODE_W-1:0];
        end else if (r == 5) begin
            return pick_extreme();
        end
        return 16'($urandom);
    endfunction

    task automatic random_window();
        logic [hawm_pkg::CODE_W-1:0] v[4];
        logic [hawm_pkg::CODE_W-1:0] t;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 5 || mode == 8) begin
            for (int k = 0; k < 4; k++) v[k] = 16'($urandom_range(1, hawm_pkg::CODE_MAX));
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3 - a; b++)
                    if (v[b] > v[b+1]) begin
                        t = v[b];
                        v[b] = v[b+1];
                        v[b+1] = t;
                    end
            if (mode == 8) begin
                if ($urandom_range(0, 1)) v[0] = '0;
                else v[2] = '0;
            end
            set_window(v[0], v[1], v[3], v[2]);
        end else if (mode < 7) begin
            write_reg(hawm_pkg::REG_LOW_SET, $urandom);
            write_reg(hawm_pkg::REG_LOW_CLEAR, $urandom);
            write_reg(hawm_pkg::REG_HIGH_SET, $urandom);
            write_reg(hawm_pkg::REG_HIGH_CLEAR, $urandom);
        end else begin
            set_window(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
        end
    endtask

    task automatic test_reset_window();
        send_sample(1'b0, 16'h0000);
        send_sample(1'b1, hawm_pkg::CODE_MAX);
        send_sample(1'b0, 16'hFFFF);
        send_sample(1'b1, 16'h5000);
    endtask

    task automatic test_hysteresis_regions();
        drain();
        set_window(16'h1000, 16'h1400, 16'h8000, 16'h7000);
        send_sample(1'b0, 16'h3000);
        send_sample(1'b0, 16'h1200);
        send_sample(1'b1, 16'h1000);   // enter low alarm at set level
        send_sample(1'b0, 16'h1200);
        send_sample(1'b1, 16'h1200);   // held by hysteresis
        send_sample(1'b1, 16'h1400);   // clears at clear level
        send_sample(1'b1, 16'h7800);
        send_sample(1'b1, 16'h8000);   // enter high alarm
        send_sample(1'b0, 16'h7800);
        send_sample(1'b1, 16'h7000);
        send_sample(1'b1, 16'hFFFF);   // above code range
        send_sample(1'b1, 16'h0000);
        send_sample(1'b1, 16'h3000);
    endtask

    task automatic test_disabled_windows();
        drain();
        write_reg(hawm_pkg::REG_LOW_CLEAR, 32'h0000_0800);   // low clear below low set
        send_sample(1'b1, 16'h0000);
        send_sample(1'b0, 16'h9000);
        drain();
        set_window(16'h0000, 16'h1400, 16'h7000, 16'h8000);
        send_sample(1'b1, 16'hA000);
        drain();
        set_window(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(1'b1, 16'hFFFF);
        drain();
        set_window(16'h2000, 16'h2400, 16'h0000, 16'h0100);   // low side only
        send_sample(1'b1, 16'h2000);
        send_sample(1'b0, 16'h9000);
        send_sample(1'b1, 16'h2400);
    endtask

    task automatic test_clamped_levels();
        drain();
        write_reg(hawm_pkg::REG_LOW_SET, 32'h0000_0100);
        write_reg(hawm_pkg::REG_LOW_CLEAR, 32'h0000_0200);
        write_reg(hawm_pkg::REG_HIGH_SET, 32'hFFFF_FFFF);
        write_reg(hawm_pkg::REG_HIGH_CLEAR, 32'h0001_C000);
        send_sample(1'b1, hawm_pkg::CODE_MAX);
        send_sample(1'b1, 16'hC000);
        send_sample(1'b0, 16'h1000);
    endtask

    task automatic test_backpressure();
        drain();
        set_window(16'h0800, 16'h0C00, 16'hA000, 16'h9000);
        hold_left = 80;
        repeat (30) send_sample(1'($urandom_range(0, 1)), pick_code());
    endtask

    task automatic test_random_windows();
        for (int p = 0; p < 10; p++) begin
            drain();
            random_window();
            repeat (60) send_sample(1'($urandom_range(0, 1)), pick_code());
        end
    endtask

    task automatic test_steady_stream();
        drain();
        set_window(16'h0400, 16'h0600, hawm_pkg::CODE_MAX, 16'hB000);
        sink_jitter = 1'b0;
        src_jitter = 1'b0;
        repeat (50) send_sample(1'($urandom_range(0, 1)), pick_code());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = 1'b0;
        i_sample_code = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        thr = '{hawm_pkg::CODE_MIN, hawm_pkg::CODE_MIN, hawm_pkg::CODE_MAX, hawm_pkg::CODE_MAX};
        in_alarm = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_window();
        test_hysteresis_regions();
        test_disabled_windows();
        test_clamped_levels();
        test_backpressure();
        test_random_windows();
        test_steady_stream();

        drain();
        repeat (8) @(posedge i_clk);
        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/hawm_pkg.sv
hdl/hawm_cfg_regs.sv
hdl/hawm_window.sv
hdl/hysteresis_alarm_window_manager.sv
bench/hysteresis_alarm_window_manager_tb.sv
